### src/cps_pkg.sv
// shared types and constants for the curve point scan block
package cps_pkg;

	localparam int unsigned XW = 32;
	localparam int unsigned OW = 33;
	localparam logic [3:0] CURVE_B = 4'd7;
	localparam logic [31:0] MOD_RESET = 32'd1000003;

	// input word
	typedef struct packed {
		logic [XW-1:0] x_coord;
		logic          start_new;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0]    points_here;
		logic [XW-1:0] y_root;
		logic          root_valid;
		logic [OW-1:0] running_order;
	} out_word_t;

	// register indexes
	typedef enum logic [0:0] {
		REG_MODULUS = 1'b0
	} reg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_X,
		ST_SQ_X,
		ST_CUBE,
		ST_ADD7,
		ST_EXP_INIT,
		ST_EXP_MUL,
		ST_EXP_SQ,
		ST_EXP_DONE,
		ST_FINISH,
		ST_OUT
	} state_t;

	// request to the shared modular unit
	typedef struct packed {
		logic          start;
		logic [63:0]   value;
	} mm_req_t;

endpackage

### src/cps_modred.sv
// shift-subtract modular reducer: value mod m, one bit per cycle
module cps_modred #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cps_pkg::mm_req_t     req,
	input  logic [MOD_WIDTH-1:0] m,
	output logic                 done,
	output logic [MOD_WIDTH-1:0] result
);

	localparam int unsigned VW = 64;
	localparam int unsigned CW = $clog2(VW + 1);

	logic [VW-1:0]        val_q;
	logic [MOD_WIDTH:0]   rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [MOD_WIDTH+1:0] shifted;
	logic [MOD_WIDTH+1:0] diff;

	// one restoring step
	assign shifted = {rem_q, val_q[VW-1]};
	assign diff    = shifted - {2'b00, m};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q <= req.value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[VW-2:0], 1'b0};
			if (!diff[MOD_WIDTH+1])
				rem_q <= diff[MOD_WIDTH:0];
			else
				rem_q <= shifted[MOD_WIDTH:0];
		end
	end

	assign result = rem_q[MOD_WIDTH-1:0];

endmodule

### src/cps_seq.sv
// sequencer: cube, euler test and root by square-and-multiply on the shared reducer
module cps_seq #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MOD_WIDTH-1:0] m,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cps_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cps_pkg::out_word_t   out_word
);

	localparam int unsigned MW = MOD_WIDTH;

	cps_pkg::state_t state_q, state_d;
	cps_pkg::mm_req_t req;
	logic           red_done;
	logic [MW-1:0]  red_res;

	logic [MW-1:0]  xr_q, v_q, acc_q, base_q, e_q;
	logic           root_pass_q;
	logic [1:0]     pts_q;
	logic [MW-1:0]  y_q;
	logic           valid_q;
	logic [cps_pkg::OW-1:0] order_q;
	logic           euler_one;
	logic           p_ok;

	cps_modred #(.MOD_WIDTH(MOD_WIDTH)) u_red (
		.clk(clk), .arst_n(arst_n), .req(req), .m(m),
		.done(red_done), .result(red_res)
	);

	assign p_ok  = (m >= MW'(3));
	assign euler_one = (acc_q == MW'(1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cps_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and reducer requests
	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.value = '0;
		unique case (state_q)
			cps_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (p_ok) begin
						state_d   = cps_pkg::ST_RED_X;
						req.start = 1'b1;
						req.value = 64'(in_word.x_coord);
					end else begin
						state_d = cps_pkg::ST_OUT;
					end
				end
			end
			cps_pkg::ST_RED_X: if (red_done) begin
				state_d = cps_pkg::ST_SQ_X; req.start = 1'b1;
				req.value = 64'(red_res) * 64'(red_res);
			end
			cps_pkg::ST_SQ_X: if (red_done) begin
				state_d = cps_pkg::ST_CUBE; req.start = 1'b1;
				req.value = 64'(red_res) * 64'(xr_q);
			end
			cps_pkg::ST_CUBE: if (red_done) begin
				state_d = cps_pkg::ST_ADD7; req.start = 1'b1;
				req.value = 64'(red_res) + 64'(cps_pkg::CURVE_B);
			end
			cps_pkg::ST_ADD7: if (red_done) state_d = cps_pkg::ST_EXP_INIT;
			cps_pkg::ST_EXP_INIT: begin
				if (v_q == '0) state_d = cps_pkg::ST_FINISH;
				else if (e_q == '0) state_d = cps_pkg::ST_EXP_DONE;
				else if (e_q[0]) begin
					state_d = cps_pkg::ST_EXP_MUL; req.start = 1'b1;
					req.value = 64'(acc_q) * 64'(base_q);
				end else begin
					state_d = cps_pkg::ST_EXP_SQ; req.start = 1'b1;
					req.value = 64'(base_q) * 64'(base_q);
				end
			end
			cps_pkg::ST_EXP_MUL: if (red_done) begin
				state_d = cps_pkg::ST_EXP_SQ; req.start = 1'b1;
				req.value = 64'(base_q) * 64'(base_q);
			end
			cps_pkg::ST_EXP_SQ: if (red_done) state_d = cps_pkg::ST_EXP_INIT;
			cps_pkg::ST_EXP_DONE: begin
				if (!root_pass_q && euler_one && m[1:0] == 2'b11)
					state_d = cps_pkg::ST_EXP_INIT;
				else
					state_d = cps_pkg::ST_FINISH;
			end
			cps_pkg::ST_FINISH: state_d = cps_pkg::ST_OUT;
			cps_pkg::ST_OUT: if (!out_stall) state_d = cps_pkg::ST_IDLE;
			default: state_d = cps_pkg::ST_IDLE;
		endcase
	end

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= cps_pkg::OW'(1);
		else if (state_q == cps_pkg::ST_IDLE && in_valid) begin
			if (in_word.start_new) order_q <= cps_pkg::OW'(1);
		end else if (state_q == cps_pkg::ST_FINISH)
			order_q <= order_q + cps_pkg::OW'(pts_q);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cps_pkg::ST_IDLE: if (in_valid) begin
				pts_q <= '0; y_q <= '0; valid_q <= 1'b0; root_pass_q <= 1'b0;
			end
			cps_pkg::ST_RED_X: if (red_done) xr_q <= red_res;
			cps_pkg::ST_ADD7: if (red_done) begin
				v_q    <= red_res;
				base_q <= red_res;
				acc_q  <= MW'(1);
				e_q    <= MW'((m - MW'(1)) >> 1);
			end
			cps_pkg::ST_EXP_MUL: if (red_done) acc_q <= red_res;
			cps_pkg::ST_EXP_SQ: if (red_done) begin
				base_q <= red_res;
				e_q    <= e_q >> 1;
			end
			cps_pkg::ST_EXP_INIT: if (v_q == '0) pts_q <= 2'd1;
			cps_pkg::ST_EXP_DONE: begin
				if (!root_pass_q) begin
					if (euler_one) pts_q <= 2'd2;
					if (euler_one && m[1:0] == 2'b11) begin
						root_pass_q <= 1'b1;
						base_q <= v_q;
						acc_q  <= MW'(1);
						e_q    <= MW'(({1'b0, m} + (MW+1)'(1)) >> 2);
					end
				end else begin
					y_q     <= acc_q;
					valid_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != cps_pkg::ST_IDLE);
	assign out_valid = (state_q == cps_pkg::ST_OUT);
	assign out_word.points_here   = pts_q;
	assign out_word.y_root        = cps_pkg::XW'(y_q);
	assign out_word.root_valid    = valid_q;
	assign out_word.running_order = order_q;

endmodule

### src/curve_point_scan.sv
// top level of the curve point scan block
// One word at a time: x is reduced, cubed plus 7, then tested by Euler's criterion
// and, for moduli 3 mod 4, rooted by a second exponentiation. Every modular product
// goes through one shared shift-subtract reducer that shifts in all 64 bits of the
// product and then hands off the result, and each exponent bit passes once through
// the EXP_INIT sequencing state. A word needs at most 4 + 4 * (MOD_WIDTH - 1)
// reductions, and fewer for small moduli, a zero v, nonresidues or moduli not
// 3 mod 4. in_stall stays high from acceptance until the result word has been
// taken.
module curve_point_scan #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cps_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cps_pkg::out_word_t   out_word
);

	logic [MOD_WIDTH-1:0] modulus_q;
	logic                 wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && (paddr == 2'd0);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= MOD_WIDTH'(cps_pkg::MOD_RESET);
		else if (wr && cps_pkg::reg_idx_t'(paddr[1:1]) == cps_pkg::REG_MODULUS)
			modulus_q <= pwdata[MOD_WIDTH-1:0];
	end

	assign prdata = 32'(modulus_q);

	cps_seq #(.MOD_WIDTH(MOD_WIDTH)) u_seq (
		.clk(clk), .arst_n(arst_n), .m(modulus_q),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
	a_pts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.points_here != 2'd3) else $error("bad count");
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.root_valid) |-> out_word.points_here == 2'd2)
		else $error("root without residue");

endmodule
